@@ rtl/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// ppc_pkg
// shared constants for the point to cylinder projection block
// ----------------------------------------------------------------------------
package ppc_pkg;

    // extra fraction bits carried by the radial distance
    localparam int GUARD_BITS = 16;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_HALF_LENGTH = 2'd0,
        REG_CYL_RADIUS  = 2'd1
    } cfg_idx_t;

endpackage

@@ rtl/ppc_point_if.sv @@
// ----------------------------------------------------------------------------
// ppc_point_if
// input point channel, valid/ready with three signed coordinates
// ----------------------------------------------------------------------------
interface ppc_point_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] px_in;
    logic signed [COORD_BITS-1:0] py_in;
    logic signed [COORD_BITS-1:0] pz_in;

    modport source (output valid, px_in, py_in, pz_in, input ready);
    modport sink   (input valid, px_in, py_in, pz_in, output ready);
endinterface

@@ rtl/ppc_result_if.sv @@
// ----------------------------------------------------------------------------
// ppc_result_if
// result channel, valid/ready with projected point and inside flag
// ----------------------------------------------------------------------------
interface ppc_result_if #(
    parameter int COORD_BITS = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] qx_out;
    logic signed [COORD_BITS-1:0] qy_out;
    logic signed [COORD_BITS-1:0] qz_out;
    logic                         is_inside;

    modport source (output valid, qx_out, qy_out, qz_out, is_inside, input ready);
    modport sink   (input valid, qx_out, qy_out, qz_out, is_inside, output ready);
endinterface

@@ rtl/ppc_sqrt.sv @@
// ----------------------------------------------------------------------------
// ppc_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module ppc_sqrt
    import ppc_pkg::*;
#(
    parameter int AW = 96
)(
    input  logic              clk,
    input  logic              en,
    input  logic [AW-1:0]     a,
    output logic [AW/2-1:0]   root
);
    localparam int RW = AW / 2;

    logic [AW-1:0] rem_reg  [RW];
    logic [RW-1:0] root_reg [RW];
    logic [AW-1:0] rem_in   [RW];
    logic [RW-1:0] root_in  [RW];

    genvar k;
    generate
        for (k = 0; k < RW; k++)
        begin : g_stage
            localparam int BI = RW - 1 - k;
            logic [AW-1:0] trial;
            logic [AW-1:0] rem_next;
            logic [RW-1:0] root_next;

            if (k == 0)
            begin : g_first
                assign rem_in[k]  = a;
                assign root_in[k] = '0;
            end
            else
            begin : g_rest
                assign rem_in[k]  = rem_reg[k-1];
                assign root_in[k] = root_reg[k-1];
            end

            always_comb
            begin
                trial     = (AW'(root_in[k]) << (BI + 1)) | (AW'(1) << (2 * BI));
                rem_next  = rem_in[k];
                root_next = root_in[k];
                if (rem_in[k] >= trial)
                begin
                    rem_next  = rem_in[k] - trial;
                    root_next = root_in[k] | (RW'(1) << BI);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[k]  <= rem_next;
                    root_reg[k] <= root_next;
                end
            end
        end
    endgenerate

    assign root = root_reg[RW-1];
endmodule

@@ rtl/ppc_div.sv @@
// ----------------------------------------------------------------------------
// ppc_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module ppc_div
    import ppc_pkg::*;
#(
    parameter int NW = 81,
    parameter int DW = 49,
    parameter int QW = 32
)(
    input  logic          clk,
    input  logic          en,
    input  logic [NW-1:0] n,
    input  logic [DW-1:0] d,
    output logic [QW-1:0] q
);
    logic [NW-1:0] r_reg [QW];
    logic [DW-1:0] d_reg [QW];
    logic [QW-1:0] q_reg [QW];
    logic [NW-1:0] r_in  [QW];
    logic [DW-1:0] d_in  [QW];
    logic [QW-1:0] q_in  [QW];

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_stage
            localparam int BI = QW - 1 - k;
            logic [NW-1:0] dsh;
            logic [NW-1:0] r_next;
            logic [QW-1:0] q_next;

            if (k == 0)
            begin : g_first
                assign r_in[k] = n;
                assign d_in[k] = d;
                assign q_in[k] = '0;
            end
            else
            begin : g_rest
                assign r_in[k] = r_reg[k-1];
                assign d_in[k] = d_reg[k-1];
                assign q_in[k] = q_reg[k-1];
            end

            always_comb
            begin
                dsh    = NW'(d_in[k]) << BI;
                r_next = r_in[k];
                q_next = q_in[k];
                if (r_in[k] >= dsh)
                begin
                    r_next = r_in[k] - dsh;
                    q_next = q_in[k] | (QW'(1) << BI);
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k] <= r_next;
                    d_reg[k] <= d_in[k];
                    q_reg[k] <= q_next;
                end
            end
        end
    endgenerate

    assign q = q_reg[QW-1];
endmodule

@@ rtl/project_point_to_cylinder.sv @@
// ----------------------------------------------------------------------------
// project_point_to_cylinder
// nearest point on a finite x-axis cylinder surface, fully pipelined
// ----------------------------------------------------------------------------
// channel   | dir | beat contents
// point     | in  | px_in, py_in, pz_in (signed fixed point)
// result    | out | qx_out, qy_out, qz_out, is_inside
// cfg       | in  | cfg_we, cfg_index, cfg_data (half_length, cyl_radius)
//
// one point per cycle sustained while the output is not stalled; the pipe
// depth is set by the square root (one bit per stage) and the divider
// (one quotient bit per stage)
// reset clears the valid bits and loads both registers with 1.0
// a stalled output freezes the whole pipe; ready is high whenever the
// output register is empty or being taken
// ----------------------------------------------------------------------------
module project_point_to_cylinder
    import ppc_pkg::*;
#(
    parameter int COORD_BITS = 32
)(
    input  logic                  clk,
    input  logic                  rst_n,
    ppc_point_if.sink             point,
    ppc_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [COORD_BITS-2:0] cfg_data
);
    localparam int C  = COORD_BITS;
    localparam int G  = GUARD_BITS;
    localparam int AW = 2 * C + 2 * G;   // radicand width
    localparam int SQ = C + G;           // root width and sqrt stages
    localparam int NW = 2 * C + G + 1;   // dividend width
    localparam int DW = C + G + 1;       // divisor width
    localparam int L  = SQ + C + 7;      // total stages

    typedef struct packed {
        logic signed [C-1:0] qx;
        logic signed [C-1:0] y;
        logic signed [C-1:0] z;
        logic                in_cyl;
        logic                radial;
        logic                zero;
        logic [2*C-2:0]      ny;
        logic [2*C-2:0]      nz;
    } sq_sb_t;

    typedef struct packed {
        logic signed [C-1:0] qx;
        logic signed [C-1:0] y;
        logic signed [C-1:0] z;
        logic                in_cyl;
        logic                radial;
        logic                zero;
        logic                bigy;
        logic                bigz;
    } dv_sb_t;

    // configuration registers
    logic [C-2:0] len_reg;
    logic [C-2:0] rad_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= (C-1)'(65536);
            rad_reg <= (C-1)'(65536);
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_HALF_LENGTH)
                len_reg <= cfg_data;
            else if (cfg_index == REG_CYL_RADIUS)
                rad_reg <= cfg_data;
        end
    end

    // pipe advance and valid chain
    logic         advance;
    logic [L-1:0] v_reg;

    assign advance     = !v_reg[L-1] || result.ready;
    assign point.ready = advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (advance)
            v_reg <= {v_reg[L-2:0], point.valid};
    end

    // stage 1: capture point
    logic signed [C-1:0] x1_reg, y1_reg, z1_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x1_reg <= point.px_in;
            y1_reg <= point.py_in;
            z1_reg <= point.pz_in;
        end
    end

    // stage 2: magnitudes, x clamp, cap distance
    logic signed [C-1:0] lens, negl;
    logic [C-1:0]        ax, ay, az;
    logic                x_hi, x_lo;
    logic [C-2:0]        dcap;
    logic signed [C-1:0] qx_clamp, capx;

    logic signed [C-1:0] y2_reg, z2_reg, qx2_reg, capx2_reg;
    logic [C-1:0]        ay2_reg, az2_reg;
    logic                inx2_reg, tv2_reg;
    logic [C-2:0]        t2_reg;

    always_comb
    begin
        lens     = $signed({1'b0, len_reg});
        negl     = -lens;
        ax       = x1_reg[C-1] ? C'(-x1_reg) : C'(x1_reg);
        ay       = y1_reg[C-1] ? C'(-y1_reg) : C'(y1_reg);
        az       = z1_reg[C-1] ? C'(-z1_reg) : C'(z1_reg);
        x_hi     = x1_reg > lens;
        x_lo     = x1_reg < negl;
        qx_clamp = x_hi ? lens : (x_lo ? negl : x1_reg);
        dcap     = len_reg - ax[C-2:0];
        // x = 0 goes to the negative cap
        capx     = (!x1_reg[C-1] && (x1_reg != '0)) ? lens : negl;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            y2_reg    <= y1_reg;
            z2_reg    <= z1_reg;
            ay2_reg   <= ay;
            az2_reg   <= az;
            qx2_reg   <= qx_clamp;
            capx2_reg <= capx;
            inx2_reg  <= !x_hi && !x_lo;
            tv2_reg   <= rad_reg > dcap;
            t2_reg    <= rad_reg - dcap;
        end
    end

    // stage 3: products
    logic [2*C-1:0]      yy3_reg, zz3_reg;
    logic [2*C-3:0]      rr3_reg, tt3_reg;
    logic [2*C-2:0]      ny3_reg, nz3_reg;
    logic signed [C-1:0] y3_reg, z3_reg, qx3_reg, capx3_reg;
    logic                inx3_reg, tv3_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            yy3_reg   <= ay2_reg * ay2_reg;
            zz3_reg   <= az2_reg * az2_reg;
            rr3_reg   <= rad_reg * rad_reg;
            tt3_reg   <= t2_reg * t2_reg;
            ny3_reg   <= (2*C-1)'(rad_reg * ay2_reg);
            nz3_reg   <= (2*C-1)'(rad_reg * az2_reg);
            y3_reg    <= y2_reg;
            z3_reg    <= z2_reg;
            qx3_reg   <= qx2_reg;
            capx3_reg <= capx2_reg;
            inx3_reg  <= inx2_reg;
            tv3_reg   <= tv2_reg;
        end
    end

    // stage 4: squared radial distance
    logic [2*C-1:0]      n24_reg;
    logic [2*C-3:0]      rr4_reg, tt4_reg;
    logic [2*C-2:0]      ny4_reg, nz4_reg;
    logic signed [C-1:0] y4_reg, z4_reg, qx4_reg, capx4_reg;
    logic                inx4_reg, tv4_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n24_reg   <= yy3_reg + zz3_reg;
            rr4_reg   <= rr3_reg;
            tt4_reg   <= tt3_reg;
            ny4_reg   <= ny3_reg;
            nz4_reg   <= nz3_reg;
            y4_reg    <= y3_reg;
            z4_reg    <= z3_reg;
            qx4_reg   <= qx3_reg;
            capx4_reg <= capx3_reg;
            inx4_reg  <= inx3_reg;
            tv4_reg   <= tv3_reg;
        end
    end

    // stage 5: region decision, cap versus side wall
    logic   gt_r, cap;
    sq_sb_t sb5;
    logic [2*C-1:0] n25_reg;
    sq_sb_t         sb5_reg;

    always_comb
    begin
        gt_r       = n24_reg > (2*C)'(rr4_reg);
        cap        = inx4_reg && !gt_r && tv4_reg && (n24_reg < (2*C)'(tt4_reg));
        sb5.qx     = cap ? capx4_reg : qx4_reg;
        sb5.y      = y4_reg;
        sb5.z      = z4_reg;
        sb5.in_cyl = inx4_reg && !gt_r;
        sb5.radial = gt_r || (inx4_reg && !cap);
        sb5.zero   = n24_reg == '0;
        sb5.ny     = ny4_reg;
        sb5.nz     = nz4_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            n25_reg <= n24_reg;
            sb5_reg <= sb5;
        end
    end

    // square root of n2 with guard bits
    logic [SQ-1:0] ng;
    sq_sb_t        sqsb_reg [SQ];

    ppc_sqrt #(.AW(AW)) u_sqrt (
        .clk  (clk),
        .en   (advance),
        .a    ({n25_reg, {(2*G){1'b0}}}),
        .root (ng)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            sqsb_reg[0] <= sb5_reg;
            for (int i = 1; i < SQ; i++)
                sqsb_reg[i] <= sqsb_reg[i-1];
        end
    end

    // prep stage: dividends for round to nearest, overflow check
    sq_sb_t        sqo;
    logic [NW-1:0] nyw, nzw, dbig;
    logic [DW-1:0] dd;
    logic [NW-1:0] ny_p_reg, nz_p_reg;
    logic [DW-1:0] d_p_reg;
    dv_sb_t        sb_p, sb_p_reg;

    always_comb
    begin
        sqo         = sqsb_reg[SQ-1];
        nyw         = NW'({sqo.ny, {(G+1){1'b0}}}) + NW'(ng);
        nzw         = NW'({sqo.nz, {(G+1){1'b0}}}) + NW'(ng);
        dd          = {ng, 1'b0};
        dbig        = NW'(dd) << C;
        sb_p.qx     = sqo.qx;
        sb_p.y      = sqo.y;
        sb_p.z      = sqo.z;
        sb_p.in_cyl = sqo.in_cyl;
        sb_p.radial = sqo.radial;
        sb_p.zero   = sqo.zero;
        sb_p.bigy   = nyw >= dbig;
        sb_p.bigz   = nzw >= dbig;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ny_p_reg <= nyw;
            nz_p_reg <= nzw;
            d_p_reg  <= dd;
            sb_p_reg <= sb_p;
        end
    end

    // scale dividers for y and z
    logic [C-1:0] qy_d, qz_d;
    dv_sb_t       dvsb_reg [C];

    ppc_div #(.NW(NW), .DW(DW), .QW(C)) u_div_y (
        .clk (clk),
        .en  (advance),
        .n   (ny_p_reg),
        .d   (d_p_reg),
        .q   (qy_d)
    );

    ppc_div #(.NW(NW), .DW(DW), .QW(C)) u_div_z (
        .clk (clk),
        .en  (advance),
        .n   (nz_p_reg),
        .d   (d_p_reg),
        .q   (qz_d)
    );

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dvsb_reg[0] <= sb_p_reg;
            for (int i = 1; i < C; i++)
                dvsb_reg[i] <= dvsb_reg[i-1];
        end
    end

    // saturate a quotient and apply the sign of the source coordinate
    function automatic logic signed [C-1:0] sat_sign(
        input logic [C-1:0] q,
        input logic         big,
        input logic         neg
    );
        logic signed [C-1:0] res;
        if (neg)
        begin
            if (big || (q[C-1] && (q[C-2:0] != '0)))
                res = {1'b1, {(C-1){1'b0}}};
            else
                res = $signed(C'(-q));
        end
        else
        begin
            if (big || q[C-1])
                res = {1'b0, {(C-1){1'b1}}};
            else
                res = $signed(q);
        end
        return res;
    endfunction

    // output stage
    dv_sb_t              dvo;
    logic signed [C-1:0] qy_f, qz_f;
    logic signed [C-1:0] qx_o_reg, qy_o_reg, qz_o_reg;
    logic                ins_o_reg;

    always_comb
    begin
        dvo  = dvsb_reg[C-1];
        qy_f = dvo.y;
        qz_f = dvo.z;
        if (dvo.radial)
        begin
            if (dvo.zero)
            begin
                // point on the axis: put it on the +y side wall
                qy_f = $signed({1'b0, rad_reg});
                qz_f = '0;
            end
            else
            begin
                qy_f = sat_sign(qy_d, dvo.bigy, dvo.y[C-1]);
                qz_f = sat_sign(qz_d, dvo.bigz, dvo.z[C-1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            qx_o_reg  <= dvo.qx;
            qy_o_reg  <= qy_f;
            qz_o_reg  <= qz_f;
            ins_o_reg <= dvo.in_cyl;
        end
    end

    assign result.valid     = v_reg[L-1];
    assign result.qx_out    = qx_o_reg;
    assign result.qy_out    = qy_o_reg;
    assign result.qz_out    = qz_o_reg;
    assign result.is_inside = ins_o_reg;

    // a stall freezes every valid bit in the pipe
    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(v_reg))
        else $error("valid chain moved during stall");

    // an accepted beat shows up in the first stage
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        point.valid && point.ready |=> v_reg[0])
        else $error("accepted beat lost at entry");

    // a beat in the stage before the output register lands in the output register
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v_reg[L-2] |=> result.valid)
        else $error("beat lost before output");

    // an inside point always takes the side wall or a cap, never keeps all coords
    a_inside_dec: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg[3] && sb5.in_cyl |-> (sb5.radial || (sb5.qx == capx4_reg)))
        else $error("inside point left unprojected");
endmodule
